/* hdl/cpet_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the client pause expiry table.
// Used by the channel interfaces, the slot cells, the sequencer and the top level.
package cpet_pkg;

    // Command codes
    localparam logic [2:0] CMD_SET       = 3'd0;
    localparam logic [2:0] CMD_CLEAR     = 3'd1;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd2;
    localparam logic [2:0] CMD_LIST      = 3'd3;
    localparam logic [2:0] CMD_QUERY     = 3'd4;
    localparam logic [2:0] CMD_TICK      = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAUSE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALL_CLIENTS = 2'd1;

    // Register reset values
    localparam logic [15:0] MAX_PAUSE_RESET   = 16'd1440;
    localparam logic [31:0] ALL_CLIENTS_RESET = 32'd0;

    // Result limits
    localparam logic [4:0] MAX_LIST_RESULTS = 5'd16;
    localparam logic [4:0] LIVE_COUNT_MAX   = 5'd31;

    // Field widths
    localparam int unsigned REM_W = 22;

    // Controls broadcast from the sequencer to every slot cell
    typedef struct packed {
        logic [31:0] now;
        logic [31:0] key;
        logic [31:0] all_addr;
        logic [31:0] new_expiry;
        logic        set_en;
        logic        use_match;
        logic        clr_match;
        logic        clr_all;
        logic        tok_start;
        logic        tok_adv;
    } cell_ctl_t;

    // Table status gathered from the cells for the sequencer
    typedef struct packed {
        logic        any_match;
        logic        any_empty;
        logic        any_qmatch;
        logic        tok_live;
        logic        tok_last;
        logic [31:0] sel_address;
        logic [31:0] sel_expiry;
    } tbl_stat_t;

endpackage

/* hdl/cpet_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the client pause expiry table:
// command items, result items and configuration writes. Depends on cpet_pkg.

interface cpet_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] client_address;
    logic [15:0] pause_minutes;
    logic [4:0]  list_limit;

    modport source (output valid, output cmd, output client_address,
                    output pause_minutes, output list_limit, input ready);
    modport sink   (input valid, input cmd, input client_address,
                    input pause_minutes, input list_limit, output ready);
endinterface

interface cpet_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         success;
    logic [4:0]                   live_count;
    logic                         entry_valid;
    logic [31:0]                  entry_address;
    logic [cpet_pkg::REM_W-1:0]   entry_remaining_seconds;
    logic                         last;

    modport source (output valid, output success, output live_count,
                    output entry_valid, output entry_address,
                    output entry_remaining_seconds, output last, input ready);
    modport sink   (input valid, input success, input live_count,
                    input entry_valid, input entry_address,
                    input entry_remaining_seconds, input last, output ready);
endinterface

interface cpet_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cpet_pkg::CFG_INDEX_W-1:0] index;
    logic [31:0]                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/cpet_cell.sv */
`timescale 1ns / 1ps
// One slot of the pause table: address, expiry, match flags and the scan token.
// Depends on cpet_pkg for the broadcast control struct.
module cpet_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  cpet_pkg::cell_ctl_t ctl,
    input  logic                hit_in,
    output logic                hit_out,
    input  logic                tok_in,
    output logic                tok,
    output logic                live,
    output logic                match,
    output logic                qmatch,
    output logic [31:0]         address,
    output logic [31:0]         expiry
);

    logic [31:0] addr_reg;
    logic [31:0] expiry_reg;
    logic        tok_reg;
    logic        hit;
    logic        grant;

    // Compare this slot against the clock and the command address
    assign live   = expiry_reg > ctl.now;
    assign match  = live && (addr_reg == ctl.key);
    assign qmatch = live && ((addr_reg == ctl.key) || (addr_reg == ctl.all_addr));

    // Take the set when this is the first candidate in the row
    assign hit     = ctl.use_match ? match : !live;
    assign grant   = ctl.set_en && hit && !hit_in;
    assign hit_out = hit_in || hit;

    // Store a set, drop on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            expiry_reg <= '0;
        end
        else if (grant)
        begin
            addr_reg   <= ctl.key;
            expiry_reg <= ctl.new_expiry;
        end
        else if (ctl.clr_all || (ctl.clr_match && match))
        begin
            expiry_reg <= '0;
        end
    end

    // Pass the scan token to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else if (ctl.tok_start || ctl.tok_adv)
        begin
            tok_reg <= tok_in;
        end
    end

    assign tok     = tok_reg;
    assign address = addr_reg;
    assign expiry  = expiry_reg;

endmodule

/* hdl/cpet_seq.sv */
`timescale 1ns / 1ps
// Command sequencer: registers, seconds counter, scan control and result register.
// Depends on cpet_pkg and the channel interfaces in cpet_ifs.sv.
module cpet_seq
#(
    parameter int unsigned SLOT_COUNT = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    cpet_req_if.sink             req,
    cpet_rsp_if.source           rsp,
    cpet_cfg_if.sink             cfg,
    input  cpet_pkg::tbl_stat_t  stat,
    output cpet_pkg::cell_ctl_t  ctl
);

    localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_COUNT = 3'd2;
    localparam logic [2:0] ST_LIST  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  cmd_reg;
    logic [31:0] key_reg;
    logic [15:0] min_reg;
    logic [4:0]  lim_reg;
    logic        success_reg, success_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [4:0]  sent_reg, sent_next;
    logic [31:0] seconds_reg, seconds_next;
    logic [15:0] max_pause_reg;
    logic [31:0] all_addr_reg;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_success_reg;
    logic [4:0]                 out_count_reg;
    logic                       out_evalid_reg;
    logic [31:0]                out_addr_reg;
    logic [cpet_pkg::REM_W-1:0] out_rem_reg;
    logic                       out_last_reg;

    logic        accept;
    logic        out_free;
    logic        min_ok;
    logic [21:0] min_secs;
    logic [32:0] exp_sum;
    logic [31:0] new_expiry;
    logic [CW-1:0] cnt_sum;
    logic [4:0]  lim_eff;
    logic [4:0]  live_sat;
    logic        entry_last;
    logic [31:0] rem_full;
    logic        load_entry;
    logic        load_summary;
    logic        tok_start;
    logic        tok_adv;
    logic        clr_all;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // Latch the command item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            key_reg <= req.client_address;
            min_reg <= req.pause_minutes;
            lim_reg <= req.list_limit;
        end
    end

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pause_reg <= cpet_pkg::MAX_PAUSE_RESET;
            all_addr_reg  <= cpet_pkg::ALL_CLIENTS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == cpet_pkg::REG_MAX_PAUSE)
            begin
                max_pause_reg <= cfg.data[15:0];
            end
            else if (cfg.index == cpet_pkg::REG_ALL_CLIENTS)
            begin
                all_addr_reg <= cfg.data;
            end
        end
    end

    // Compute the set expiry: minutes * 60 added to now, saturated
    assign min_ok     = (min_reg != 16'd0) && (min_reg <= max_pause_reg);
    assign min_secs   = {min_reg, 6'b0} - 22'({min_reg, 2'b0});
    assign exp_sum    = {1'b0, seconds_reg} + 33'(min_secs);
    assign new_expiry = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

    assign cnt_sum  = cnt_reg + CW'(stat.tok_live);
    assign lim_eff  = (lim_reg > cpet_pkg::MAX_LIST_RESULTS) ? cpet_pkg::MAX_LIST_RESULTS
                                                            : lim_reg;
    assign live_sat = (32'(cnt_reg) > 32'(cpet_pkg::LIVE_COUNT_MAX))
                      ? cpet_pkg::LIVE_COUNT_MAX : 5'(cnt_reg);
    assign entry_last = ((sent_reg + 5'd1) == lim_eff)
                        || ((32'(sent_reg) + 32'd1) == 32'(cnt_reg));
    assign rem_full   = stat.sel_expiry - seconds_reg;

    // Sequence one command: execute, count, then either a list scan or a summary
    always_comb
    begin
        state_next   = state_reg;
        success_next = success_reg;
        cnt_next     = cnt_reg;
        sent_next    = sent_reg;
        seconds_next = seconds_reg;
        tok_start    = 1'b0;
        tok_adv      = 1'b0;
        clr_all      = 1'b0;
        load_entry   = 1'b0;
        load_summary = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (cmd_reg)
                    cpet_pkg::CMD_SET:
                        success_next = min_ok && (stat.any_match || stat.any_empty);
                    cpet_pkg::CMD_CLEAR:
                        success_next = stat.any_match;
                    cpet_pkg::CMD_QUERY:
                        success_next = stat.any_qmatch;
                    default:
                        success_next = 1'b0;
                endcase
                if ((cmd_reg == cpet_pkg::CMD_TICK) && (seconds_reg != 32'hFFFF_FFFF))
                begin
                    seconds_next = seconds_reg + 32'd1;
                end
                cnt_next   = '0;
                tok_start  = 1'b1;
                state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                cnt_next = cnt_sum;
                tok_adv  = 1'b1;
                if (stat.tok_last)
                begin
                    clr_all = (cmd_reg == cpet_pkg::CMD_CLEAR_ALL);
                    if ((cmd_reg == cpet_pkg::CMD_LIST) && (lim_eff != 5'd0)
                        && (cnt_sum != '0))
                    begin
                        tok_start  = 1'b1;
                        sent_next  = 5'd0;
                        state_next = ST_LIST;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_LIST:
            begin
                if (!stat.tok_live)
                begin
                    tok_adv = 1'b1;
                end
                else if (out_free)
                begin
                    load_entry = 1'b1;
                    tok_adv    = 1'b1;
                    sent_next  = sent_reg + 5'd1;
                    if (entry_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    load_summary = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            success_reg <= 1'b0;
            cnt_reg     <= '0;
            sent_reg    <= 5'd0;
            seconds_reg <= 32'd0;
        end
        else
        begin
            state_reg   <= state_next;
            success_reg <= success_next;
            cnt_reg     <= cnt_next;
            sent_reg    <= sent_next;
            seconds_reg <= seconds_next;
        end
    end

    // Drive the cells
    always_comb
    begin
        ctl.now        = seconds_reg;
        ctl.key        = key_reg;
        ctl.all_addr   = all_addr_reg;
        ctl.new_expiry = new_expiry;
        ctl.set_en     = (state_reg == ST_EXEC) && (cmd_reg == cpet_pkg::CMD_SET) && min_ok;
        ctl.use_match  = stat.any_match;
        ctl.clr_match  = (state_reg == ST_EXEC) && (cmd_reg == cpet_pkg::CMD_CLEAR);
        ctl.clr_all    = clr_all;
        ctl.tok_start  = tok_start;
        ctl.tok_adv    = tok_adv;
    end

    // Hold the result item until it is taken
    assign out_valid_next = (load_entry || load_summary) ? 1'b1
                          : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_entry)
        begin
            out_success_reg <= 1'b0;
            out_count_reg   <= live_sat;
            out_evalid_reg  <= 1'b1;
            out_addr_reg    <= stat.sel_address;
            out_rem_reg     <= rem_full[cpet_pkg::REM_W-1:0];
            out_last_reg    <= entry_last;
        end
        else if (load_summary)
        begin
            out_success_reg <= success_reg;
            out_count_reg   <= live_sat;
            out_evalid_reg  <= 1'b0;
            out_addr_reg    <= 32'd0;
            out_rem_reg     <= '0;
            out_last_reg    <= 1'b1;
        end
    end

    assign rsp.valid                   = out_valid_reg;
    assign rsp.success                 = out_success_reg;
    assign rsp.live_count              = out_count_reg;
    assign rsp.entry_valid             = out_evalid_reg;
    assign rsp.entry_address           = out_addr_reg;
    assign rsp.entry_remaining_seconds = out_rem_reg;
    assign rsp.last                    = out_last_reg;

endmodule

/* hdl/client_pause_expiry_table.sv */
`timescale 1ns / 1ps
// Client pause expiry table: a row of slot cells and the command sequencer.
// Depends on cpet_pkg, cpet_ifs.sv, cpet_cell and cpet_seq.
//
// Usage:
//   req carries one command item (set, clear, clear all, list, query, tick).
//   rsp returns the result items of that command; last marks the final one.
//   cfg writes max_pause_minutes (index 0) or all_clients_address (index 1);
//   it is always ready and must only be used while the block is idle.
// Flow:
//   A command is taken when req.ready is high, which is when no earlier
//   command is still running. The command executes first, then a token
//   walks the slot row one cell per cycle to count live entries. A
//   non-list command, or a list with nothing to emit, then loads its
//   result into the output register, and the next command can be taken.
//   A list walks the row a second time and emits one entry per live slot,
//   up to the list limit, holding while the output register is full; the
//   next command can be taken once the final entry is loaded.
// Stall:
//   Results sit in an output register; while rsp.ready is low the list scan
//   holds on the live slot it reached, and the next command may already be
//   accepted while the final result of the previous one waits.
// Reset:
//   rst_n empties every slot, zeroes the seconds counter and restores the
//   register defaults (1440 minutes, all-clients address 0).
module client_pause_expiry_table
#(
    parameter int unsigned SLOT_COUNT = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    cpet_req_if.sink    req,
    cpet_rsp_if.source  rsp,
    cpet_cfg_if.sink    cfg
);

    cpet_pkg::cell_ctl_t ctl;
    cpet_pkg::tbl_stat_t stat;

    logic [SLOT_COUNT:0]   hit_chain;
    logic [SLOT_COUNT-1:0] tok_feed;
    logic [SLOT_COUNT-1:0] tok_vec;
    logic [SLOT_COUNT-1:0] live_vec;
    logic [SLOT_COUNT-1:0] match_vec;
    logic [SLOT_COUNT-1:0] qmatch_vec;
    logic [31:0]           addr_arr   [SLOT_COUNT];
    logic [31:0]           expiry_arr [SLOT_COUNT];
    logic [31:0]           sel_address;
    logic [31:0]           sel_expiry;

    assign hit_chain[0] = 1'b0;

    // Build the row of slot cells
    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign tok_feed[i] = ctl.tok_start;
        end
        else
        begin : g_body
            assign tok_feed[i] = tok_vec[i-1] && !ctl.tok_start;
        end

        cpet_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .hit_in  (hit_chain[i]),
            .hit_out (hit_chain[i+1]),
            .tok_in  (tok_feed[i]),
            .tok     (tok_vec[i]),
            .live    (live_vec[i]),
            .match   (match_vec[i]),
            .qmatch  (qmatch_vec[i]),
            .address (addr_arr[i]),
            .expiry  (expiry_arr[i])
        );
    end

    // Select the slot under the token
    always_comb
    begin
        sel_address = 32'd0;
        sel_expiry  = 32'd0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (tok_vec[i])
            begin
                sel_address = sel_address | addr_arr[i];
                sel_expiry  = sel_expiry | expiry_arr[i];
            end
        end
    end

    // Gather the table status
    always_comb
    begin
        stat.any_match   = |match_vec;
        stat.any_empty   = !(&live_vec);
        stat.any_qmatch  = |qmatch_vec;
        stat.tok_live    = |(tok_vec & live_vec);
        stat.tok_last    = tok_vec[SLOT_COUNT-1];
        stat.sel_address = sel_address;
        stat.sel_expiry  = sel_expiry;
    end

    cpet_seq
    #(
        .SLOT_COUNT (SLOT_COUNT)
    )
    u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .stat  (stat),
        .ctl   (ctl)
    );

endmodule

/* dv/tb_client_pause_expiry_table.sv */
`timescale 1ns / 1ps
// Self-checking bench for client_pause_expiry_table: directed, register, backpressure
// and random command runs checked against an in-bench slot table predictor.
// Depends on cpet_pkg, the channel interfaces in cpet_ifs.sv and the RTL top level.
module tb_client_pause_expiry_table;

    localparam int SLOTS         = 16;
    localparam int POOL_SIZE     = 24;
    localparam int PHASE_ITEMS   = 125;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
    localparam int MAX_REPORTS   = 40;
    localparam int TIMEOUT_NS    = 20_000_000;

    // Codes outside the defined command set, and register indexes with no register
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam logic [cpet_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [cpet_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] client_address;
        logic [15:0] pause_minutes;
        logic [4:0]  list_limit;
    } pause_cmd_t;

    typedef struct packed {
        logic                       success;
        logic [4:0]                 live_count;
        logic                       entry_valid;
        logic [31:0]                entry_address;
        logic [cpet_pkg::REM_W-1:0] entry_remaining_seconds;
        logic                       last;
    } pause_result_t;

    logic clk;
    logic rst_n;

    cpet_req_if req_ch ();
    cpet_rsp_if rsp_ch ();
    cpet_cfg_if cfg_ch ();

    client_pause_expiry_table #(.SLOT_COUNT(SLOTS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predicted table state and register copies
    bit [31:0] slot_addr [SLOTS];
    bit [31:0] slot_expiry [SLOTS];
    bit [31:0] seconds_now;
    bit [15:0] max_minutes;
    bit [31:0] all_clients;

    pause_result_t pending_results [$];
    bit [31:0]     address_pool [POOL_SIZE];

    int fail_count    = 0;
    int send_idle_pct = 7;
    int recv_idle_pct = 60;
    int hold_request  = 0;
    int hold_left     = 0;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic bit slot_live(int i);
        return slot_expiry[i] > seconds_now;
    endfunction

    function automatic int live_entries();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_live(i))
                n++;
        return n;
    endfunction

    function automatic void push_result(logic ok, int count, logic valid, logic [31:0] addr,
                                        logic [31:0] remaining, logic last);
        pause_result_t r;
        r.success                 = ok;
        r.live_count              = (count > 31) ? 5'd31 : count[4:0];
        r.entry_valid             = valid;
        r.entry_address           = addr;
        r.entry_remaining_seconds = remaining[cpet_pkg::REM_W-1:0];
        r.last                    = last;
        pending_results.push_back(r);
    endfunction

    // Apply one command to the predicted table and queue its results
    function automatic void predict_command(pause_cmd_t c);
        bit [63:0] expiry;
        int        target;
        int        count;
        int        lim;
        int        total;
        int        emitted;
        logic      ok;
        ok = 1'b0;
        case (c.op)
            cpet_pkg::CMD_SET:
            begin
                if (c.pause_minutes != 0 && c.pause_minutes <= max_minutes)
                begin
                    // expiry saturates at the top of the 32-bit range
                    expiry = seconds_now;
                    expiry = expiry + c.pause_minutes * 64'd60;
                    if (expiry > 64'hFFFF_FFFF)
                        expiry = 64'hFFFF_FFFF;
                    target = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (target < 0 && slot_live(i) && slot_addr[i] == c.client_address)
                            target = i;
                    for (int i = 0; i < SLOTS; i++)
                        if (target < 0 && !slot_live(i))
                            target = i;
                    if (target >= 0)
                    begin
                        slot_addr[target]   = c.client_address;
                        slot_expiry[target] = expiry[31:0];
                        ok = 1'b1;
                    end
                end
                push_result(ok, live_entries(), 1'b0, '0, '0, 1'b1);
            end
            cpet_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_live(i) && slot_addr[i] == c.client_address)
                    begin
                        slot_expiry[i] = '0;
                        ok = 1'b1;
                    end
                end
                push_result(ok, live_entries(), 1'b0, '0, '0, 1'b1);
            end
            cpet_pkg::CMD_CLEAR_ALL:
            begin
                count = live_entries();
                for (int i = 0; i < SLOTS; i++)
                    slot_expiry[i] = '0;
                push_result(1'b0, count, 1'b0, '0, '0, 1'b1);
            end
            cpet_pkg::CMD_LIST:
            begin
                count = live_entries();
                lim   = (c.list_limit > cpet_pkg::MAX_LIST_RESULTS)
                        ? cpet_pkg::MAX_LIST_RESULTS : c.list_limit;
                total = (count < lim) ? count : lim;
                emitted = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_live(i) && emitted < total)
                    begin
                        push_result(1'b0, count, 1'b1, slot_addr[i],
                                    slot_expiry[i] - seconds_now, emitted == total - 1);
                        emitted++;
                    end
                end
                // nothing to show: one empty closing result
                if (total == 0)
                    push_result(1'b0, count, 1'b0, '0, '0, 1'b1);
            end
            cpet_pkg::CMD_QUERY:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live(i) && (slot_addr[i] == all_clients ||
                                         slot_addr[i] == c.client_address))
                        ok = 1'b1;
                push_result(ok, live_entries(), 1'b0, '0, '0, 1'b1);
            end
            cpet_pkg::CMD_TICK:
            begin
                if (seconds_now != 32'hFFFF_FFFF)
                    seconds_now++;
                push_result(1'b0, live_entries(), 1'b0, '0, '0, 1'b1);
            end
            default:
                push_result(1'b0, live_entries(), 1'b0, '0, '0, 1'b1);
        endcase
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            if (fail_count < MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        pause_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $error("result item with nothing pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("success", want.success, rsp_ch.success);
                check_field("live_count", want.live_count, rsp_ch.live_count);
                check_field("entry_valid", want.entry_valid, rsp_ch.entry_valid);
                check_field("entry_address", want.entry_address, rsp_ch.entry_address);
                check_field("entry_remaining_seconds", want.entry_remaining_seconds,
                            rsp_ch.entry_remaining_seconds);
                check_field("last", want.last, rsp_ch.last);
            end
        end
    end

    // Result side stalls: random, or a long counted hold when requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one command item, with an optional idle gap, and predict it on acceptance
    task automatic send_command(input logic [2:0] op, input logic [31:0] addr,
                                input logic [15:0] minutes, input logic [4:0] limit);
        pause_cmd_t c;
        c.op             = op;
        c.client_address = addr;
        c.pause_minutes  = minutes;
        c.list_limit     = limit;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid          <= 1'b1;
        req_ch.cmd            <= op;
        req_ch.client_address <= addr;
        req_ch.pause_minutes  <= minutes;
        req_ch.list_limit     <= limit;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_command(c);
    endtask

    // Drop valid and hold until every predicted result has arrived
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; only called while the block is idle
    task automatic write_reg(input logic [cpet_pkg::CFG_INDEX_W-1:0] index,
                             input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (index)
            cpet_pkg::REG_MAX_PAUSE:   max_minutes = data[15:0];
            cpet_pkg::REG_ALL_CLIENTS: all_clients = data;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Field extremes, every command, rejects, replacement, list limits and spare codes
    task automatic test_directed();
        send_command(cpet_pkg::CMD_QUERY, 32'h0, 16'd0, 5'd0);
        send_command(cpet_pkg::CMD_LIST, 32'h0, 16'd0, 5'd5);
        send_command(cpet_pkg::CMD_SET, 32'hFFFF_FFFF, 16'd0, 5'd0);
        send_command(cpet_pkg::CMD_SET, 32'hFFFF_FFFF, 16'd1441, 5'd0);
        send_command(cpet_pkg::CMD_SET, 32'hFFFF_FFFF, 16'd1440, 5'd31);
        send_command(cpet_pkg::CMD_SET, 32'h0, 16'd1, 5'd0);
        send_command(cpet_pkg::CMD_SET, 32'hFFFF_FFFF, 16'd5, 5'd0);
        send_command(cpet_pkg::CMD_SET, 32'hA5A5_5A5A, 16'hFFFF, 5'd0);
        send_command(cpet_pkg::CMD_QUERY, 32'h1234_5678, 16'hFFFF, 5'd31);
        send_command(cpet_pkg::CMD_QUERY, 32'hFFFF_FFFF, 16'd0, 5'd0);
        send_command(cpet_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 5'd31);
        send_command(cpet_pkg::CMD_LIST, 32'h0, 16'd0, 5'd16);
        send_command(cpet_pkg::CMD_LIST, 32'h0, 16'd0, 5'd1);
        send_command(cpet_pkg::CMD_LIST, 32'h0, 16'd0, 5'd0);
        send_command(cpet_pkg::CMD_LIST, 32'h0, 16'd0, 5'd31);
        send_command(cpet_pkg::CMD_CLEAR, 32'h1234_5678, 16'd0, 5'd0);
        send_command(cpet_pkg::CMD_CLEAR, 32'h0, 16'd0, 5'd0);
        send_command(cpet_pkg::CMD_QUERY, 32'h1234_5678, 16'd0, 5'd0);
        send_command(CMD_SPARE_6, 32'h5555_AAAA, 16'd7, 5'd3);
        send_command(CMD_SPARE_7, 32'hAAAA_5555, 16'd9, 5'd2);
        send_command(cpet_pkg::CMD_CLEAR_ALL, 32'h0, 16'd0, 5'd0);
        send_command(cpet_pkg::CMD_CLEAR_ALL, 32'h0, 16'd0, 5'd0);
        wait_idle();
    endtask

    // Both registers at their extremes, ignored indexes, then defaults back
    task automatic test_registers();
        wait_idle();
        write_reg(cpet_pkg::REG_MAX_PAUSE, 32'd65535);
        write_reg(cpet_pkg::REG_ALL_CLIENTS, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_2, 32'd5);
        write_reg(REG_SPARE_3, 32'h1234);
        send_command(cpet_pkg::CMD_SET, 32'h0A00_0001, 16'd65535, 5'd0);
        send_command(cpet_pkg::CMD_LIST, 32'h0, 16'd0, 5'd16);
        send_command(cpet_pkg::CMD_QUERY, 32'h0102_0304, 16'd0, 5'd0);
        send_command(cpet_pkg::CMD_SET, 32'hFFFF_FFFF, 16'd1, 5'd0);
        send_command(cpet_pkg::CMD_QUERY, 32'h0102_0304, 16'd0, 5'd0);
        wait_idle();
        write_reg(cpet_pkg::REG_MAX_PAUSE, 32'd1);
        send_command(cpet_pkg::CMD_SET, 32'h0A00_0002, 16'd2, 5'd0);
        send_command(cpet_pkg::CMD_SET, 32'h0A00_0002, 16'd1, 5'd0);
        send_command(cpet_pkg::CMD_CLEAR_ALL, 32'h0, 16'd0, 5'd0);
        wait_idle();
        write_reg(cpet_pkg::REG_MAX_PAUSE, {16'd0, cpet_pkg::MAX_PAUSE_RESET});
        write_reg(cpet_pkg::REG_ALL_CLIENTS, cpet_pkg::ALL_CLIENTS_RESET);
    endtask

    // Long result stall while commands keep coming, with a full table and a
    // rejected set, then pause until the backlog drains
    task automatic test_backpressure();
        wait_idle();
        hold_request = 400;
        for (int k = 0; k < SLOTS; k++)
            send_command(cpet_pkg::CMD_SET, address_pool[k], 16'd10, 5'd0);
        send_command(cpet_pkg::CMD_SET, 32'hC0A8_0101, 16'd10, 5'd0);
        for (int k = 0; k < 4; k++)
        begin
            send_command(cpet_pkg::CMD_LIST, 32'h0, 16'd0, 5'd16);
            send_command(cpet_pkg::CMD_QUERY, address_pool[k + SLOTS], 16'd0, 5'd0);
        end
        wait_idle();
        send_command(cpet_pkg::CMD_CLEAR_ALL, 32'h0, 16'd0, 5'd0);
        wait_idle();
    endtask

    // Random command biased toward pool addresses and short pauses so that
    // matches, replacements and expiry all happen
    task automatic send_random();
        logic [2:0]  op;
        logic [31:0] addr;
        logic [15:0] minutes;
        logic [4:0]  limit;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 35)
            op = cpet_pkg::CMD_SET;
        else if (pick < 45)
            op = cpet_pkg::CMD_CLEAR;
        else if (pick < 48)
            op = cpet_pkg::CMD_CLEAR_ALL;
        else if (pick < 58)
            op = cpet_pkg::CMD_LIST;
        else if (pick < 78)
            op = cpet_pkg::CMD_QUERY;
        else
            op = cpet_pkg::CMD_TICK;
        addr = ($urandom_range(99) < 80) ? address_pool[$urandom_range(POOL_SIZE - 1)]
                                         : $urandom;
        pick = $urandom_range(99);
        if (pick < 10)
            minutes = 16'd0;
        else if (pick < 70)
            minutes = 16'($urandom_range(3, 1));
        else if (pick < 80)
            minutes = max_minutes;
        else if (pick < 85)
            minutes = max_minutes + 16'd1;
        else
            minutes = 16'($urandom);
        limit = ($urandom_range(99) < 5) ? 5'($urandom_range(31, 17))
                                         : 5'($urandom_range(16, 0));
        send_command(op, addr, minutes, limit);
    endtask

    // One random phase under the given idle rates and a fresh register setting
    task automatic test_random_phase(input int send_pct, input int recv_pct);
        int sent;
        int burst;
        int pick;
        wait_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        pick = $urandom_range(3);
        case (pick)
            0:       write_reg(cpet_pkg::REG_MAX_PAUSE, 32'd1);
            1:       write_reg(cpet_pkg::REG_MAX_PAUSE, 32'd65535);
            2:       write_reg(cpet_pkg::REG_MAX_PAUSE, 32'd3);
            default: write_reg(cpet_pkg::REG_MAX_PAUSE, $urandom_range(10, 2));
        endcase
        write_reg(cpet_pkg::REG_ALL_CLIENTS, address_pool[$urandom_range(POOL_SIZE - 1)]);
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            // occasionally fill the table with distinct addresses
            if ($urandom_range(99) < 6)
            begin
                burst = $urandom_range(20, 16);
                for (int k = 0; k < burst; k++)
                    send_command(cpet_pkg::CMD_SET, address_pool[k],
                                 16'($urandom_range(3, 1)), 5'd0);
                sent += burst;
            end
            else
            begin
                send_random();
                sent++;
            end
        end
    endtask

    // Reset, run every test in turn, report
    initial
    begin
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.cmd            = cpet_pkg::CMD_QUERY;
        req_ch.client_address = '0;
        req_ch.pause_minutes  = '0;
        req_ch.list_limit     = '0;
        rsp_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = cpet_pkg::REG_MAX_PAUSE;
        cfg_ch.data           = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_addr[i]   = '0;
            slot_expiry[i] = '0;
        end
        seconds_now = '0;
        max_minutes = cpet_pkg::MAX_PAUSE_RESET;
        all_clients = cpet_pkg::ALL_CLIENTS_RESET;
        address_pool[0] = 32'h0;
        address_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            address_pool[i] = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_registers();
        test_backpressure();
        test_random_phase(7, 60);
        test_random_phase(60, 7);
        test_random_phase(0, 0);
        wait_idle();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/cpet_pkg.sv
hdl/cpet_ifs.sv
hdl/cpet_cell.sv
hdl/cpet_seq.sv
hdl/client_pause_expiry_table.sv
dv/tb_client_pause_expiry_table.sv
